// File: design/gnp_pkg.sv
// Shared types and constants for the gradient noise point evaluator.
// No dependencies; every other design file but gnp_ifs refers to it by scoped names.
`timescale 1ns / 1ps

package gnp_pkg;

  // Command codes of the input word
  localparam logic [2:0] CMD_PERM_FIRST  = 3'd0;
  localparam logic [2:0] CMD_PERM_SECOND = 3'd1;
  localparam logic [2:0] CMD_PERM_THIRD  = 3'd2;
  localparam logic [2:0] CMD_GRADIENT    = 3'd3;
  localparam logic [2:0] CMD_EVALUATE    = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_SEED_INDEX   = 3'd0;
  localparam logic [2:0] REG_INPUT_SCALE  = 3'd1;
  localparam logic [2:0] REG_OUTPUT_SCALE = 3'd2;
  localparam logic [2:0] REG_OFFSET_X     = 3'd3;
  localparam logic [2:0] REG_OFFSET_Y     = 3'd4;

  localparam logic [31:0] SCALE_ONE = 32'h0100_0000;
  localparam logic [31:0] SAT_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN   = 32'h8000_0000;

  // Widest fraction the datapath supports
  localparam int FRAC_MAX = 24;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [7:0]          idx;
    logic [7:0]          val;
    logic [31:0]         grad;
    logic [7:0]          cx;
    logic [7:0]          cy;
    logic [FRAC_MAX-1:0] fx;
    logic [FRAC_MAX-1:0] fy;
  } item_t;

  typedef struct packed {
    logic [31:0] pos_gain;
    logic [31:0] pos_bias_x;
    logic [31:0] pos_bias_y;
  } front_cfg_t;

  typedef struct packed {
    logic [7:0]  seed_index;
    logic [31:0] amp_gain;
  } back_cfg_t;

endpackage

// File: design/gnp_ifs.sv
// Valid/ready channel interfaces for the input and result words.
// No dependencies.
`timescale 1ns / 1ps

interface gnp_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [7:0]         entry_index;
  logic [7:0]         entry_value;
  logic signed [15:0] grad_x;
  logic signed [15:0] grad_y;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;

  modport source(output valid, command, entry_index, entry_value, grad_x, grad_y,
                 pos_x, pos_y, input ready);
  modport sink(input valid, command, entry_index, entry_value, grad_x, grad_y,
               pos_x, pos_y, output ready);
endinterface

interface gnp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] noise_value;
  logic               saturated;

  modport source(output valid, noise_value, saturated, input ready);
  modport sink(input valid, noise_value, saturated, output ready);
endinterface

// File: design/gnp_front.sv
// Front end: accepts input words, drops unused commands, and splits the
// scaled position into lattice cell and fraction. Uses gnp_pkg, gnp_in_if.
`timescale 1ns / 1ps

module gnp_front #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  gnp_in_if.sink              in,
  input  gnp_pkg::front_cfg_t cfg,
  input  logic                full,
  output logic                push,
  output gnp_pkg::item_t      push_item
);

  logic               fe;
  logic               s0_v;
  logic [2:0]         s0_cmd;
  logic [7:0]         s0_idx;
  logic [7:0]         s0_val;
  logic [31:0]        s0_grad;
  logic signed [32:0] s0_sx;
  logic signed [32:0] s0_sy;

  logic               s1_v;
  logic [2:0]         s1_cmd;
  logic [7:0]         s1_idx;
  logic [7:0]         s1_val;
  logic [31:0]        s1_grad;
  logic [41:0]        s1_lox;
  logic [25:0]        s1_hix;
  logic [41:0]        s1_loy;
  logic [25:0]        s1_hiy;

  logic signed [49:0] lox;
  logic signed [49:0] hix;
  logic signed [49:0] loy;
  logic signed [49:0] hiy;
  logic [41:0]        ux;
  logic [41:0]        uy;

  // stall the whole front while the queue cannot take its last word
  assign fe       = !(s1_v && full);
  assign in.ready = fe;
  assign push     = s1_v && !full;

  // partial products of the 33 x 32 bit position scaling
  assign lox = 50'(s0_sx) * 50'($signed({1'b0, cfg.pos_gain[15:0]}));
  assign hix = 50'(s0_sx) * 50'($signed({1'b0, cfg.pos_gain[31:16]}));
  assign loy = 50'(s0_sy) * 50'($signed({1'b0, cfg.pos_gain[15:0]}));
  assign hiy = 50'(s0_sy) * 50'($signed({1'b0, cfg.pos_gain[31:16]}));

  assign ux = s1_lox + {s1_hix, 16'b0};
  assign uy = s1_loy + {s1_hiy, 16'b0};

  always_comb begin
    push_item      = '0;
    push_item.cmd  = s1_cmd;
    push_item.idx  = s1_idx;
    push_item.val  = s1_val;
    push_item.grad = s1_grad;
    push_item.cx   = ux[41:34];
    push_item.cy   = uy[41:34];
    push_item.fx   = gnp_pkg::FRAC_MAX'(ux[33 -: FRACTION_BITS]);
    push_item.fy   = gnp_pkg::FRAC_MAX'(uy[33 -: FRACTION_BITS]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
    end else if (fe) begin
      s0_v <= in.valid && (in.command <= gnp_pkg::CMD_EVALUATE);
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      s0_cmd  <= in.command;
      s0_idx  <= in.entry_index;
      s0_val  <= in.entry_value;
      s0_grad <= {in.grad_y, in.grad_x};
      s0_sx   <= {in.pos_x[31], in.pos_x} + {cfg.pos_bias_x[31], cfg.pos_bias_x};
      s0_sy   <= {in.pos_y[31], in.pos_y} + {cfg.pos_bias_y[31], cfg.pos_bias_y};
      s1_cmd  <= s0_cmd;
      s1_idx  <= s0_idx;
      s1_val  <= s0_val;
      s1_grad <= s0_grad;
      s1_lox  <= lox[41:0];
      s1_hix  <= hix[25:0];
      s1_loy  <= loy[41:0];
      s1_hiy  <= hiy[25:0];
    end
  end

endmodule

// File: design/gnp_queue.sv
// Short word queue between front and back ends.
// Uses gnp_pkg for the word type and depth.
`timescale 1ns / 1ps

module gnp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gnp_pkg::item_t push_item,
  input  logic           pop,
  output gnp_pkg::item_t head,
  output logic           empty,
  output logic           full
);

  localparam int AW = $clog2(gnp_pkg::QUEUE_DEPTH);

  gnp_pkg::item_t slots [gnp_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           do_pop;

  assign empty  = (count == '0);
  assign full   = (count == (AW+1)'(gnp_pkg::QUEUE_DEPTH));
  assign head   = slots[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

// File: design/gnp_back.sv
// Back end: table loads and lookups, four corner lanes, sum, output scaling
// and saturation. Uses gnp_pkg and gnp_out_if.
`timescale 1ns / 1ps

module gnp_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  gnp_pkg::back_cfg_t cfg,
  input  gnp_pkg::item_t     head,
  input  logic               empty,
  output logic               pop,
  gnp_out_if.source          out
);

  localparam int F   = FRACTION_BITS;
  localparam int SQW = 2 * F + 1;
  localparam int TW  = F + 1;
  localparam int PW  = F + 17;
  localparam int DW  = F + 4;
  localparam int MW  = F + 6;
  localparam int SW  = F + 8;
  localparam int RW  = F + 40;

  logic be;

  logic [7:0]  perm1_mem [256];
  logic [7:0]  perm2_mem [256];
  logic [7:0]  perm3_mem [256];
  logic [31:0] grad0_mem [256];
  logic [31:0] grad1_mem [256];

  // stage A: permutation reads
  logic        a_v;
  logic [2:0]  a_cmd;
  logic [7:0]  a_idx;
  logic [31:0] a_grad;
  logic [F-1:0] a_fx;
  logic [F-1:0] a_fy;
  logic [7:0]  a_base;
  logic [7:0]  a_s0;
  logic [7:0]  a_s1;
  logic [7:0]  a_t0;
  logic [7:0]  a_t1;
  logic [7:0]  hash [4];
  logic [F:0]  mx;
  logic [F:0]  my;

  // stage B: gradient reads and squares
  logic         b_v;
  logic [F-1:0] b_fx;
  logic [F-1:0] b_fy;
  logic [31:0]  b_g [4];
  logic [SQW-1:0] b_sqx [2];
  logic [SQW-1:0] b_sqy [2];

  // stage C: falloff and dot partials
  logic                 c_v;
  logic [TW-1:0]        c_t [4];
  logic signed [PW-1:0] c_px [4];
  logic signed [PW-1:0] c_py [4];

  logic                 d_v;
  logic [TW-1:0]        d_t [4];
  logic [TW-1:0]        d_t2 [4];
  logic signed [DW-1:0] d_dot [4];

  logic                 e_v;
  logic [TW-1:0]        e_t3 [4];
  logic signed [DW-1:0] e_dot [4];

  logic                 f_v;
  logic signed [MW-1:0] f_term [4];

  logic                 g_v;
  logic signed [SW-1:0] g_sum;

  logic                 h_v;
  logic signed [RW-1:0] h_prod;

  logic signed [RW-1:0] res;
  logic [RW-32:0]       res_hi;
  logic                 res_sat;

  assign be  = !out.valid || out.ready;
  assign pop = be;

  assign mx = (F+1)'(1) << F;
  assign my = (F+1)'(1) << F;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hash[k] = a_base ^ (k[1] ? a_s1 : a_s0) ^ (k[0] ? a_t1 : a_t0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
      h_v <= 1'b0;
      out.valid <= 1'b0;
    end else if (be) begin
      a_v <= !empty;
      b_v <= a_v && (a_cmd == gnp_pkg::CMD_EVALUATE);
      c_v <= b_v;
      d_v <= c_v;
      e_v <= d_v;
      f_v <= e_v;
      g_v <= f_v;
      h_v <= g_v;
      out.valid <= h_v;
    end
  end

  // permutation tables: loads write as they leave the queue
  always_ff @(posedge clk) begin
    if (be) begin
      if (!empty && head.cmd == gnp_pkg::CMD_PERM_FIRST) perm1_mem[head.idx] <= head.val;
      if (!empty && head.cmd == gnp_pkg::CMD_PERM_SECOND) perm2_mem[head.idx] <= head.val;
      if (!empty && head.cmd == gnp_pkg::CMD_PERM_THIRD) perm3_mem[head.idx] <= head.val;
      a_base <= perm1_mem[cfg.seed_index];
      a_s0   <= perm2_mem[head.cy];
      a_s1   <= perm2_mem[8'(head.cy + 8'd1)];
      a_t0   <= perm3_mem[head.cx];
      a_t1   <= perm3_mem[8'(head.cx + 8'd1)];
      a_cmd  <= head.cmd;
      a_idx  <= head.idx;
      a_grad <= head.grad;
      a_fx   <= head.fx[F-1:0];
      a_fy   <= head.fy[F-1:0];
    end
  end

  // gradient table held twice to give four read ports
  always_ff @(posedge clk) begin
    if (be) begin
      if (a_v && a_cmd == gnp_pkg::CMD_GRADIENT) begin
        grad0_mem[a_idx] <= a_grad;
        grad1_mem[a_idx] <= a_grad;
      end
      b_g[0] <= grad0_mem[hash[0]];
      b_g[1] <= grad0_mem[hash[1]];
      b_g[2] <= grad1_mem[hash[2]];
      b_g[3] <= grad1_mem[hash[3]];
      b_fx   <= a_fx;
      b_fy   <= a_fy;
      // far corner distance squared uses one minus the fraction
      b_sqx[0] <= SQW'(a_fx) * SQW'(a_fx);
      b_sqx[1] <= SQW'(mx - (F+1)'(a_fx)) * SQW'(mx - (F+1)'(a_fx));
      b_sqy[0] <= SQW'(a_fy) * SQW'(a_fy);
      b_sqy[1] <= SQW'(my - (F+1)'(a_fy)) * SQW'(my - (F+1)'(a_fy));
    end
  end

  always_ff @(posedge clk) begin
    logic [SQW:0]         r2;
    logic [SQW:0]         one2;
    logic signed [F:0]    dx;
    logic signed [F:0]    dy;
    logic signed [15:0]   gx;
    logic signed [15:0]   gy;
    logic [2*F+1:0]       tt;
    logic [2*F+1:0]       ttt;
    logic signed [PW:0]   dsum;
    logic signed [2*F+5:0] tp;
    if (be) begin
      one2 = (SQW+1)'(1) << (2 * F);
      for (int k = 0; k < 4; k++) begin
        r2 = (SQW+1)'(b_sqx[k[0]]) + (SQW+1)'(b_sqy[k[1]]);
        c_t[k] <= (r2 >= one2) ? '0 : TW'((one2 - r2) >> F);
        // near corner offset is the fraction, far corner the fraction minus one
        dx = $signed({k[0], b_fx});
        dy = $signed({k[1], b_fy});
        gx = $signed(b_g[k][15:0]);
        gy = $signed(b_g[k][31:16]);
        c_px[k] <= PW'(dx) * PW'(gx);
        c_py[k] <= PW'(dy) * PW'(gy);

        tt = (2*F+2)'(c_t[k]) * (2*F+2)'(c_t[k]);
        d_t2[k] <= TW'(tt >> F);
        d_t[k]  <= c_t[k];
        dsum = (PW+1)'(c_px[k]) + (PW+1)'(c_py[k]);
        d_dot[k] <= DW'(dsum >>> 14);

        ttt = (2*F+2)'(d_t2[k]) * (2*F+2)'(d_t[k]);
        e_t3[k]  <= TW'(ttt >> F);
        e_dot[k] <= d_dot[k];

        tp = (2*F+6)'(e_dot[k]) * (2*F+6)'($signed({1'b0, e_t3[k]}));
        f_term[k] <= MW'(tp >>> F);
      end
      g_sum  <= SW'(f_term[0]) + SW'(f_term[1]) + SW'(f_term[2]) + SW'(f_term[3]);
      h_prod <= RW'(g_sum) * RW'($signed(cfg.amp_gain));
    end
  end

  assign res     = h_prod >>> (F + 8);
  assign res_hi  = res[RW-1:31];
  assign res_sat = !((&res_hi) || !(|res_hi));

  always_ff @(posedge clk) begin
    if (be) begin
      out.saturated <= res_sat;
      if (res_sat) begin
        out.noise_value <= res[RW-1] ? gnp_pkg::SAT_MIN : gnp_pkg::SAT_MAX;
      end else begin
        out.noise_value <= res[31:0];
      end
    end
  end

endmodule

// File: design/gradient_noise_point_eval.sv
// Gradient noise point evaluator: one input word per cycle unless stalled, fully pipelined.
// An evaluate word passes the 2 front stages, the queue, the 8 back stages and the
// output register to its result. Throughput: one word per cycle when results
// are not stalled, set by the four parallel corner lanes.
// Reset clears control and configuration; the tables are undefined until loaded.
`timescale 1ns / 1ps

module gradient_noise_point_eval #(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  gnp_in_if.sink      in,
  gnp_out_if.source   out,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  gnp_pkg::front_cfg_t front_cfg;
  gnp_pkg::back_cfg_t  back_cfg;
  gnp_pkg::item_t      push_item;
  gnp_pkg::item_t      head;
  logic                push;
  logic                pop;
  logic                full;
  logic                empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      back_cfg.seed_index   <= '0;
      front_cfg.pos_gain    <= gnp_pkg::SCALE_ONE;
      back_cfg.amp_gain     <= gnp_pkg::SCALE_ONE;
      front_cfg.pos_bias_x  <= '0;
      front_cfg.pos_bias_y  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gnp_pkg::REG_SEED_INDEX:   back_cfg.seed_index  <= cfg_data[7:0];
        gnp_pkg::REG_INPUT_SCALE:  front_cfg.pos_gain   <= cfg_data;
        gnp_pkg::REG_OUTPUT_SCALE: back_cfg.amp_gain    <= cfg_data;
        gnp_pkg::REG_OFFSET_X:     front_cfg.pos_bias_x <= cfg_data;
        gnp_pkg::REG_OFFSET_Y:     front_cfg.pos_bias_y <= cfg_data;
        default: ;
      endcase
    end
  end

  gnp_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in        (in),
    .cfg       (front_cfg),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  gnp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  gnp_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (back_cfg),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .out   (out)
  );

endmodule

// File: test/noise_checker.sv
// Checker for the gradient noise point evaluator: mirrors the tables and registers,
// predicts each evaluate result and compares it with the result channel.
// Depends on gnp_pkg and the channel interfaces in gnp_ifs.
`timescale 1ns / 1ps

module noise_checker (
  input  logic        clk,
  input  logic        rst,
  gnp_in_if           in_mon,
  gnp_out_if          out_mon,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam int FB = 16;

  typedef struct {
    logic [31:0] noise_value;
    logic        saturated;
  } noise_word_t;

  logic [7:0]  perm_a [256];
  logic [7:0]  perm_b [256];
  logic [7:0]  perm_c [256];
  logic [31:0] grads  [256];
  logic [7:0]  seed_sel;
  logic [31:0] in_scale;
  logic [31:0] out_scale;
  logic [31:0] off_x;
  logic [31:0] off_y;
  noise_word_t expected_noise [$];

  function automatic longint corner_weight(longint dx, longint dy, logic [31:0] g);
    longint one2, r2, t, t3, dot, gx, gy;
    one2 = longint'(1) <<< (2 * FB);
    r2 = dx * dx + dy * dy;
    t = one2 - ((r2 < one2) ? r2 : one2);
    t = t >>> FB;
    t3 = (t * t) >>> FB;
    t3 = (t3 * t) >>> FB;
    gx = longint'($signed(g[15:0]));
    gy = longint'($signed(g[31:16]));
    dot = (dx * gx + dy * gy) >>> 14;
    return (dot * t3) >>> FB;
  endfunction

  // Lattice cell sits in bits 41:34 of the scaled position; fraction just below
  function automatic void lattice_split(logic [31:0] pos, logic [31:0] off,
                                        output logic [7:0] lat_cell, output longint frac);
    longint s;
    longint unsigned u;
    s = longint'($signed(pos)) + longint'($signed(off));
    u = longint'(s) * longint'({32'd0, in_scale});
    lat_cell = u[41:34];
    frac = longint'(u[33:34-FB]);
  endfunction

  function automatic noise_word_t predict_noise(logic [31:0] px, logic [31:0] py);
    noise_word_t w;
    logic [7:0] cx, cy, hx, hy, h;
    longint fx, fy, sum, res, dx, dy;
    lattice_split(px, off_x, cx, fx);
    lattice_split(py, off_y, cy, fy);
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      hx = k[0] ? cx + 8'd1 : cx;
      hy = k[1] ? cy + 8'd1 : cy;
      h = perm_a[seed_sel] ^ perm_b[hy] ^ perm_c[hx];
      dx = fx - (k[0] ? (longint'(1) <<< FB) : 0);
      dy = fy - (k[1] ? (longint'(1) <<< FB) : 0);
      sum += corner_weight(dx, dy, grads[h]);
    end
    res = (sum * longint'($signed(out_scale))) >>> (FB + 8);
    w.saturated = 1'b0;
    if (res > longint'(32'sh7FFF_FFFF)) begin
      res = longint'($signed(gnp_pkg::SAT_MAX));
      w.saturated = 1'b1;
    end else if (res < longint'($signed(gnp_pkg::SAT_MIN))) begin
      res = longint'($signed(gnp_pkg::SAT_MIN));
      w.saturated = 1'b1;
    end
    w.noise_value = res[31:0];
    return w;
  endfunction

  always @(posedge clk) begin
    noise_word_t want;
    int bad;
    bad = 0;
    if (rst) begin
      seed_sel <= '0;
      in_scale <= gnp_pkg::SCALE_ONE;
      out_scale <= gnp_pkg::SCALE_ONE;
      off_x <= '0;
      off_y <= '0;
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          gnp_pkg::REG_SEED_INDEX:   seed_sel <= cfg_data[7:0];
          gnp_pkg::REG_INPUT_SCALE:  in_scale <= cfg_data;
          gnp_pkg::REG_OUTPUT_SCALE: out_scale <= cfg_data;
          gnp_pkg::REG_OFFSET_X:     off_x <= cfg_data;
          gnp_pkg::REG_OFFSET_Y:     off_y <= cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.command)
          gnp_pkg::CMD_PERM_FIRST:  perm_a[in_mon.entry_index] = in_mon.entry_value;
          gnp_pkg::CMD_PERM_SECOND: perm_b[in_mon.entry_index] = in_mon.entry_value;
          gnp_pkg::CMD_PERM_THIRD:  perm_c[in_mon.entry_index] = in_mon.entry_value;
          gnp_pkg::CMD_GRADIENT:
            grads[in_mon.entry_index] = {in_mon.grad_y, in_mon.grad_x};
          gnp_pkg::CMD_EVALUATE:
            expected_noise.push_back(predict_noise(in_mon.pos_x, in_mon.pos_y));
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_noise.size() == 0) begin
          $error("unexpected result word: noise_value %0d", $signed(out_mon.noise_value));
          bad++;
        end else begin
          want = expected_noise.pop_front();
          if (out_mon.noise_value !== want.noise_value) begin
            $error("noise_value expected %0d got %0d", $signed(want.noise_value),
                   $signed(out_mon.noise_value));
            bad++;
          end
          if (out_mon.saturated !== want.saturated) begin
            $error("saturated expected %0d got %0d", want.saturated, out_mon.saturated);
            bad++;
          end
        end
      end
      errors <= errors + bad;
      pending <= expected_noise.size();
    end
  end
endmodule

// File: test/testbench.sv
// Top of the gradient noise evaluator test: clock, reset, stimulus, idling and verdict.
// Depends on gnp_pkg, gnp_ifs, the block itself and noise_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          errors;
  int          pending;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          hold_cycles = 0;
  bit          hold_req = 1'b0;
  int          quiet = 0;

  gnp_in_if  in_ch ();
  gnp_out_if out_ch ();

  gradient_noise_point_eval i_dut (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  noise_checker i_checker (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always #6 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = gnp_pkg::CMD_EVALUATE;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    in_ch.grad_x = '0;
    in_ch.grad_y = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req && hold_cycles == 0) hold_cycles <= 400;
    else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    out_ch.ready <= !rst && hold_cycles == 0 && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send_word(logic [2:0] cmd, logic [7:0] idx, logic [7:0] val,
                           logic [15:0] gx, logic [15:0] gy,
                           logic [31:0] px, logic [31:0] py);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.entry_index <= idx;
    in_ch.entry_value <= val;
    in_ch.grad_x <= gx;
    in_ch.grad_y <= gy;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic evaluate(logic [31:0] px, logic [31:0] py);
    send_word(gnp_pkg::CMD_EVALUATE, 8'($urandom), 8'($urandom), 16'($urandom),
              16'($urandom), px, py);
  endtask

  // Drain, let in-flight loads settle, then set all five registers
  task automatic set_registers(logic [7:0] seed, logic [31:0] iscale, logic [31:0] oscale,
                               logic [31:0] ox, logic [31:0] oy);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= gnp_pkg::REG_SEED_INDEX;   cfg_data <= {24'd0, seed};   @(posedge clk);
    cfg_index <= gnp_pkg::REG_INPUT_SCALE;  cfg_data <= iscale;          @(posedge clk);
    cfg_index <= gnp_pkg::REG_OUTPUT_SCALE; cfg_data <= oscale;          @(posedge clk);
    cfg_index <= gnp_pkg::REG_OFFSET_X;     cfg_data <= ox;              @(posedge clk);
    cfg_index <= gnp_pkg::REG_OFFSET_Y;     cfg_data <= oy;              @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] random_position();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(8191) - 4096;
      2: return {14'd0, 8'($urandom_range(255)), 10'h3FF}
                + 32'(int'($urandom_range(2)) - 1);
      default: return $signed($urandom_range(65535) - 32768) <<< $urandom_range(12);
    endcase
  endfunction

  task automatic random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 68) evaluate(random_position(), random_position());
    else if (pick < 93)
      send_word(3'($urandom_range(gnp_pkg::CMD_GRADIENT)), 8'($urandom), 8'($urandom),
                16'($urandom), 16'($urandom), $urandom, $urandom);
    else send_word(3'($urandom_range(7, 5)), 8'($urandom), 8'($urandom), 16'($urandom),
                   16'($urandom), $urandom, $urandom);
  endtask

  logic [7:0]  seeds   [6] = '{8'd0, 8'd255, 8'd17, 8'd128, 8'd1, 8'd200};
  logic [31:0] iscales [6] = '{gnp_pkg::SCALE_ONE, 32'hFFFF_FFFF, 32'h0000_0000,
                               32'h0040_0000, 32'h0000_0001, 32'h0A00_0000};
  logic [31:0] oscales [6] = '{gnp_pkg::SCALE_ONE, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'hFF00_0000, 32'h0000_0000, 32'h0123_4567};
  logic [31:0] offs_x  [6] = '{32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345,
                               32'hFFFF_F800, 32'h0000_0400};
  logic [31:0] offs_y  [6] = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFE_0000,
                               32'h0000_0200, 32'h0003_0000};

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every table entry so that no evaluate touches an unwritten one
    for (int t = 0; t < 4; t++)
      for (int e = 0; e < 256; e++)
        send_word(3'(t), 8'(e), 8'($urandom), 16'($urandom), 16'($urandom),
                  $urandom, $urandom);

    // Directed: field extremes, lattice wrap, unused commands
    evaluate(32'h7FFF_FFFF, 32'h8000_0000);
    evaluate(32'h8000_0000, 32'h7FFF_FFFF);
    evaluate(32'h0, 32'h0);
    evaluate({14'd0, 8'd255, 10'h200}, {14'd0, 8'd255, 10'h3FF});
    evaluate(32'hFFFF_FFFF, 32'hFFFF_FC00);
    evaluate(32'h0000_0200, 32'h0000_0200);
    send_word(gnp_pkg::CMD_GRADIENT, 8'd0, 8'd0, 16'h8000, 16'h7FFF, '0, '0);
    send_word(gnp_pkg::CMD_GRADIENT, 8'd255, 8'd0, 16'h7FFF, 16'h8000, '0, '0);
    send_word(gnp_pkg::CMD_PERM_FIRST, 8'd0, 8'd255, '0, '0, '0, '0);
    send_word(gnp_pkg::CMD_PERM_SECOND, 8'd255, 8'd0, '0, '0, '0, '0);
    send_word(gnp_pkg::CMD_PERM_THIRD, 8'd128, 8'd128, '0, '0, '0, '0);
    send_word(3'd5, 8'd1, 8'd2, 16'h1, 16'h2, 32'h3, 32'h4);
    send_word(3'd6, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(3'd7, 8'd0, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0);
    evaluate(32'h0000_0C00, 32'hFFFF_FE00);

    for (int ph = 0; ph < 6; ph++) begin
      set_registers(seeds[ph], iscales[ph], oscales[ph], offs_x[ph], offs_y[ph]);
      send_idle = (ph < 2) ? 23 : (ph < 4) ? 70 : 0;
      recv_idle = (ph < 2) ? 70 : (ph < 4) ? 23 : 0;
      evaluate(32'h7FFF_FFFF, 32'h8000_0000);
      for (int n = 0; n < 55; n++) begin
        if (ph == 1 && n == 10) hold_req <= 1'b1;
        if (ph == 1 && n == 11) hold_req <= 1'b0;
        if (ph == 3 && n == 30) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        random_word();
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/gnp_pkg.sv
design/gnp_ifs.sv
design/gnp_front.sv
design/gnp_queue.sv
design/gnp_back.sv
design/gradient_noise_point_eval.sv
test/noise_checker.sv
test/testbench.sv
